// ----- sv/ric_pkg.sv -----
// ----------------------------------------------------------------------------
// ric_pkg
// Shared types and constants of the reprojection inlier counter.
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int MAX_POINTS = 65536;
  localparam int INLIER_CAP = (MAX_POINTS > 131071) ? 131071 : MAX_POINTS;
  localparam int NUM_REGS   = 8;
  localparam int ADDR_W     = 6;
  localparam int DIV_STEPS  = 64;

  localparam logic [2:0] REG_ROT_A   = 3'd0;
  localparam logic [2:0] REG_ROT_B   = 3'd1;
  localparam logic [2:0] REG_ROT_C   = 3'd2;
  localparam logic [2:0] REG_TRANS   = 3'd3;
  localparam logic [2:0] REG_INTR_A  = 3'd4;
  localparam logic [2:0] REG_INTR_B  = 3'd5;
  localparam logic [2:0] REG_INTR_C  = 3'd6;
  localparam logic [2:0] REG_THRESH  = 3'd7;

  typedef struct packed {
    logic [2:0][53:0] rot;
    logic [59:0]      trans;
    logic [2:0][62:0] intr;
    logic [31:0]      thr;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       mac_en;
    logic       phase;
    logic [1:0] row;
    logic [1:0] col;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       sq_en;
    logic       sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic p2_bad;
    logic out_free;
  } status_t;

endpackage

// ----- sv/reprojection_inlier_counter_core.sv -----
// ----------------------------------------------------------------------------
// reprojection_inlier_counter_core
// Projects each world point through pose and camera matrix and tests it.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    world_x/y/z, obs_u, obs_v, last_point
// out      output     out_valid/out_ready  is_inlier, point_index, inlier_total,
//                                          depth_bad, set_done
// cfg      input      APB, pready tied 1   8 registers at 8*i, 64-bit data
//
// an item is accepted, then the shared multiply-accumulate runs a pose pass
// and a camera-matrix pass; nonpositive depth goes straight to the result,
// else two 64-step radix-2 divisions follow, each with a setup (the first also
// checks depth) and a store, then the squaring of both offsets and the result load.
// the result register frees the sequencer, so a new item is taken while the
// previous result waits; the last step stalls until that result is taken.
// synchronous reset clears counters, control and registers to their defaults.
// ----------------------------------------------------------------------------
module reprojection_inlier_counter_core
  import ric_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] world_x,
  input  logic signed [19:0] world_y,
  input  logic signed [19:0] world_z,
  input  logic signed [15:0] obs_u,
  input  logic signed [15:0] obs_v,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_inlier,
  output logic [15:0]        point_index,
  output logic [16:0]        inlier_total,
  output logic               depth_bad,
  output logic               set_done
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ric_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ric_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .status, .cmd
  );

  ric_datapath u_dp (
    .clk, .rst, .cfg, .cmd, .status,
    .world_x, .world_y, .world_z, .obs_u, .obs_v, .last_point,
    .out_valid, .out_ready, .is_inlier, .point_index, .inlier_total,
    .depth_bad, .set_done
  );

`ifndef ASSERT_OFF
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer took a second item while busy");

  a_inlier_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_inlier) |-> !depth_bad)
    else $error("inlier reported with bad depth");

  a_inlier_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_inlier) |-> (inlier_total != 17'd0))
    else $error("inlier reported with zero running count");
`endif

endmodule

// ----- sv/ric_regs.sv -----
// ----------------------------------------------------------------------------
// ric_regs
// APB register file holding pose, camera matrix and distance threshold.
// ----------------------------------------------------------------------------
module ric_regs
  import ric_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot[0]  <= 54'd65536;
      cfg.rot[1]  <= 54'd17179869184;
      cfg.rot[2]  <= 54'd4503599627370496;
      cfg.trans   <= '0;
      cfg.intr[0] <= 63'd256;
      cfg.intr[1] <= 63'd536870912;
      cfg.intr[2] <= 63'd1125899906842624;
      cfg.thr     <= 32'd256;
    end else if (wr) begin
      unique case (idx)
        REG_ROT_A:  cfg.rot[0]  <= pwdata[53:0];
        REG_ROT_B:  cfg.rot[1]  <= pwdata[53:0];
        REG_ROT_C:  cfg.rot[2]  <= pwdata[53:0];
        REG_TRANS:  cfg.trans   <= pwdata[59:0];
        REG_INTR_A: cfg.intr[0] <= pwdata[62:0];
        REG_INTR_B: cfg.intr[1] <= pwdata[62:0];
        REG_INTR_C: cfg.intr[2] <= pwdata[62:0];
        REG_THRESH: cfg.thr     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROT_A:  prdata = {10'd0, cfg.rot[0]};
      REG_ROT_B:  prdata = {10'd0, cfg.rot[1]};
      REG_ROT_C:  prdata = {10'd0, cfg.rot[2]};
      REG_TRANS:  prdata = {4'd0, cfg.trans};
      REG_INTR_A: prdata = {1'b0, cfg.intr[0]};
      REG_INTR_B: prdata = {1'b0, cfg.intr[1]};
      REG_INTR_C: prdata = {1'b0, cfg.intr[2]};
      REG_THRESH: prdata = {32'd0, cfg.thr};
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- sv/ric_ctrl.sv -----
// ----------------------------------------------------------------------------
// ric_ctrl
// Sequencer: multiply-accumulate passes, two divisions, squares, result.
// ----------------------------------------------------------------------------
module ric_ctrl
  import ric_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAC  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_DFIN = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic       phase, phase_next;
  logic [1:0] row, row_next;
  logic [1:0] col, col_next;
  logic [5:0] step, step_next;
  logic       sel, sel_next;
  logic       sq, sq_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    row_next   = row;
    col_next   = col;
    step_next  = step;
    sel_next   = sel;
    sq_next    = sq;
    cmd        = '0;
    cmd.phase  = phase;
    cmd.row    = row;
    cmd.col    = col;
    cmd.sel    = sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          phase_next  = 1'b0;
          row_next    = '0;
          col_next    = '0;
          sel_next    = 1'b0;
          sq_next     = 1'b0;
          state_next  = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (col == 2'd2) begin
          col_next = '0;
          if (row == 2'd2) begin
            row_next = '0;
            if (phase) state_next = S_CHK;
            else phase_next = 1'b1;
          end else begin
            row_next = row + 2'd1;
          end
        end else begin
          col_next = col + 2'd1;
        end
      end
      S_CHK: begin
        // squaring pass reuses this state after both divisions
        if (sq) begin
          cmd.sq_en = 1'b1;
          if (sel) state_next = S_FIN;
          sel_next = 1'b1;
        end else if (status.p2_bad) begin
          state_next = S_FIN;
        end else begin
          cmd.div_load = 1'b1;
          step_next    = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 6'd1;
        if (step == 6'(DIV_STEPS - 1)) state_next = S_DFIN;
      end
      S_DFIN: begin
        cmd.div_store = 1'b1;
        state_next    = S_CHK;
        if (sel) begin
          sq_next  = 1'b1;
          sel_next = 1'b0;
        end else begin
          sel_next = 1'b1;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      row   <= '0;
      col   <= '0;
      step  <= '0;
      sel   <= 1'b0;
      sq    <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      row   <= row_next;
      col   <= col_next;
      step  <= step_next;
      sel   <= sel_next;
      sq    <= sq_next;
    end
  end

endmodule

// ----- sv/ric_datapath.sv -----
// ----------------------------------------------------------------------------
// ric_datapath
// Shared multiplier, radix-2 divider, distance test, counters, result register.
// ----------------------------------------------------------------------------
module ric_datapath
  import ric_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic signed [19:0] world_x,
  input  logic signed [19:0] world_y,
  input  logic signed [19:0] world_z,
  input  logic signed [15:0] obs_u,
  input  logic signed [15:0] obs_v,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_inlier,
  output logic [15:0]        point_index,
  output logic [16:0]        inlier_total,
  output logic               depth_bad,
  output logic               set_done
);

  logic signed [19:0] w [3];
  logic signed [15:0] ou, ov;
  logic               last;
  logic signed [31:0] cam [3];
  logic signed [63:0] p [3];
  logic signed [63:0] acc;

  logic signed [20:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [52:0] prod;
  logic signed [63:0] trans_ext, acc_base, mac_sum;

  always_comb begin
    if (!cmd.phase) begin
      mul_a = 21'(signed'(cfg.rot[cmd.row][18*cmd.col +: 18]));
      mul_b = 32'(w[cmd.col]);
    end else begin
      mul_a = signed'(cfg.intr[cmd.row][21*cmd.col +: 21]);
      mul_b = cam[cmd.col];
    end
    prod      = mul_a * mul_b;
    trans_ext = 64'(signed'(cfg.trans[20*cmd.row +: 20])) <<< 16;
    if (cmd.col == 2'd0) acc_base = cmd.phase ? 64'sd0 : trans_ext;
    else acc_base = acc;
    mac_sum = acc_base + 64'(prod);
  end

  // divider on magnitudes, floor correction applied at the end
  logic signed [63:0] num, den, mag;
  logic               neg, dneg;
  logic [64:0]        rem, trial;
  logic [63:0]        quo;
  logic               ge;
  logic [65:0]        qmag;
  logic signed [65:0] qs, dd, ad;
  logic [16:0]        clamp, cu, cv, sq_in;
  logic [33:0]        sq_p;
  logic [34:0]        sq_dist;

  always_comb begin
    num   = ((cmd.sel ? p[1] : p[0]) <<< 5) + p[2];
    den   = p[2] <<< 1;
    neg   = num[63];
    mag   = neg ? -num : num;
    trial = {rem[63:0], quo[63]};
    ge    = trial >= {1'b0, den};
    qmag  = {2'b00, quo} + 66'((dneg && (rem != '0)) ? 1 : 0);
    qs    = dneg ? -signed'(qmag) : signed'(qmag);
    dd    = qs - 66'(cmd.sel ? ov : ou);
    ad    = dd[65] ? -dd : dd;
    clamp = (ad > 66'sd65536) ? 17'd65536 : ad[16:0];
    sq_in = cmd.sel ? cv : cu;
    sq_p  = sq_in * sq_in;
  end

  logic        bad, inlier;
  logic [16:0] pc_inc;
  logic [15:0] pc, pc_next;
  logic [16:0] ic, ic_next;

  always_comb begin
    bad     = p[2][63] || (p[2] == 64'sd0);
    inlier  = !bad && (sq_dist < {3'b000, cfg.thr});
    ic_next = (inlier && (ic < 17'(INLIER_CAP))) ? ic + 17'd1 : ic;
    pc_inc  = {1'b0, pc} + 17'd1;
    if (last || (32'(pc_inc) >= 32'(MAX_POINTS))) pc_next = '0;
    else pc_next = pc_inc[15:0];
  end

  assign status.p2_bad   = bad;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      w[0] <= world_x;
      w[1] <= world_y;
      w[2] <= world_z;
      ou   <= obs_u;
      ov   <= obs_v;
      last <= last_point;
    end
    if (cmd.mac_en) begin
      acc <= mac_sum;
      if (cmd.col == 2'd2) begin
        if (cmd.phase) p[cmd.row] <= mac_sum;
        else cam[cmd.row] <= 32'(mac_sum >>> 8);
      end
    end
    if (cmd.div_load) begin
      rem  <= '0;
      quo  <= mag;
      dneg <= neg;
    end
    if (cmd.div_step) begin
      rem <= ge ? trial - {1'b0, den} : trial;
      quo <= {quo[62:0], ge};
    end
    if (cmd.div_store) begin
      if (cmd.sel) cv <= clamp;
      else cu <= clamp;
    end
    if (cmd.sq_en) sq_dist <= (cmd.sel ? sq_dist : 35'd0) + 35'(sq_p);
    if (cmd.out_load) begin
      is_inlier    <= inlier;
      point_index  <= pc;
      inlier_total <= ic_next;
      depth_bad    <= bad;
      set_done     <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pc        <= '0;
      ic        <= '0;
    end else begin
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.out_load) begin
        pc <= pc_next;
        ic <= last ? 17'd0 : ic_next;
      end
    end
  end

endmodule
